>>> src/ar3d_pkg.sv
`timescale 1ns / 1ps

package ar3d_pkg;

    localparam int CORDIC_STEPS = 24;

    // x/y datapath in Q2.30 with headroom, z is the residual phase in 2^-32 turns
    localparam int XY_W   = 34;
    localparam int Z_W    = 33;
    localparam int FACT_W = 32;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    localparam logic [31:0] ATAN_TABLE [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

>>> src/ar3d_cordic.sv
`timescale 1ns / 1ps

module ar3d_cordic #(
    parameter int ANGLE_WIDTH = 16,
    parameter int SIDE_WIDTH  = 50
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [ANGLE_WIDTH-1:0]             angle,
    input  logic [SIDE_WIDTH-1:0]              side_in,
    output logic                               out_valid,
    output logic signed [ar3d_pkg::FACT_W-1:0] cos_val,
    output logic signed [ar3d_pkg::FACT_W-1:0] sin_val,
    output logic [SIDE_WIDTH-1:0]              side_out
);
    import ar3d_pkg::*;

    localparam int PAD_W = 32 - ANGLE_WIDTH;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [31:0] phase;

    logic                   valid_reg  [0:CORDIC_STEPS];
    logic                   valid_next [0:CORDIC_STEPS];
    logic [1:0]             quad_reg   [0:CORDIC_STEPS];
    logic [1:0]             quad_next  [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] x_reg      [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] x_next     [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg      [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] y_next     [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg      [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_next     [0:CORDIC_STEPS];
    logic [SIDE_WIDTH-1:0]  side_reg   [0:CORDIC_STEPS];
    logic [SIDE_WIDTH-1:0]  side_next  [0:CORDIC_STEPS];

    logic                     out_valid_reg;
    logic signed [FACT_W-1:0] cos_reg;
    logic signed [FACT_W-1:0] cos_next;
    logic signed [FACT_W-1:0] sin_reg;
    logic signed [FACT_W-1:0] sin_next;
    logic [SIDE_WIDTH-1:0]    side_out_reg;

    assign phase = {angle, {PAD_W{1'b0}}};

    always_comb
    begin
        logic signed [Z_W-1:0] arc;
        arc           = '0;
        valid_next[0] = in_valid;
        quad_next[0]  = phase[31:30];
        x_next[0]     = CORDIC_GAIN;
        y_next[0]     = '0;
        z_next[0]     = signed'({{(Z_W-30){1'b0}}, phase[29:0]});
        side_next[0]  = side_in;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            arc              = signed'({{(Z_W-32){1'b0}}, ATAN_TABLE[i]});
            valid_next[i+1]  = valid_reg[i];
            quad_next[i+1]   = quad_reg[i];
            side_next[i+1]   = side_reg[i];
            if (!z_reg[i][Z_W-1])
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - arc;
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + arc;
            end
        end
    end

    always_comb
    begin
        case (quad_reg[CORDIC_STEPS])
            QUAD_1:
            begin
                cos_next = FACT_W'(-y_reg[CORDIC_STEPS]);
                sin_next = FACT_W'(x_reg[CORDIC_STEPS]);
            end
            QUAD_2:
            begin
                cos_next = FACT_W'(-x_reg[CORDIC_STEPS]);
                sin_next = FACT_W'(-y_reg[CORDIC_STEPS]);
            end
            QUAD_3:
            begin
                cos_next = FACT_W'(y_reg[CORDIC_STEPS]);
                sin_next = FACT_W'(-x_reg[CORDIC_STEPS]);
            end
            QUAD_0:
            begin
                cos_next = FACT_W'(x_reg[CORDIC_STEPS]);
                sin_next = FACT_W'(y_reg[CORDIC_STEPS]);
            end
            default:
            begin
                cos_next = FACT_W'(x_reg[CORDIC_STEPS]);
                sin_next = FACT_W'(y_reg[CORDIC_STEPS]);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CORDIC_STEPS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k <= CORDIC_STEPS; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
            out_valid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= CORDIC_STEPS; k++)
            begin
                quad_reg[k] <= quad_next[k];
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                side_reg[k] <= side_next[k];
            end
            cos_reg      <= cos_next;
            sin_reg      <= sin_next;
            side_out_reg <= side_reg[CORDIC_STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign cos_val   = cos_reg;
    assign sin_val   = sin_reg;
    assign side_out  = side_out_reg;

    // residual angle must have converged after the last micro-rotation
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[CORDIC_STEPS] |->
            (z_reg[CORDIC_STEPS] < Z_W'(256)) && (z_reg[CORDIC_STEPS] > -Z_W'(256)))
        else $error("cordic residual did not converge");

    // factors must fit the truncated multiplier operand
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (cos_reg < 32'sh4800_0000) && (cos_reg > -32'sh4800_0000) &&
            (sin_reg < 32'sh4800_0000) && (sin_reg > -32'sh4800_0000))
        else $error("cordic factor out of range");

endmodule

>>> src/axis_rotation_3d_top.sv
`timescale 1ns / 1ps

// Rotates a 3D point (signed Q8.8) about the x, y or z axis by a 16-bit phase angle
// (65536 = one turn). kind 0/1/2 picks x/y/z; kind 3 passes the point through.
// Input channel: in_valid/in_stall with kind, x_in, y_in, z_in, angle.
// Output channel: out_valid/out_stall with x_out, y_out, z_out, one result per request.
// A request is taken on a clock edge with valid high and stall low.
// The pipeline is one setup stage, 24 CORDIC micro-rotation stages, quadrant
// fold, multiply, round/saturate and the output register.
// Throughput is one request per cycle while the receiver does not stall; every stage
// is registered and the pipeline is fully filled by a back-to-back stream.
// When the receiver stalls a valid result, the whole pipeline holds and in_stall
// rises in the same cycle; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline; out_valid is low after it.
module axis_rotation_3d_top #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic signed [COORD_WIDTH-1:0] x_in,
    input  logic signed [COORD_WIDTH-1:0] y_in,
    input  logic signed [COORD_WIDTH-1:0] z_in,
    input  logic [ANGLE_WIDTH-1:0]        angle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] x_out,
    output logic signed [COORD_WIDTH-1:0] y_out,
    output logic signed [COORD_WIDTH-1:0] z_out
);
    import ar3d_pkg::*;

    localparam int SIDE_W = 2 + 3 * COORD_WIDTH;
    localparam int PROD_W = COORD_WIDTH + FACT_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << 29;
    localparam logic signed [SUM_W-1:0] COORD_MAX  = (SUM_W'(1) << (COORD_WIDTH - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] COORD_MIN  = ~COORD_MAX;

    function automatic logic signed [COORD_WIDTH-1:0] round_sat(
        input logic signed [SUM_W-1:0] acc
    );
        logic signed [SUM_W-1:0] q;
        q = (acc + ROUND_BIAS) >>> 30;
        if (q > COORD_MAX)
            return COORD_MAX[COORD_WIDTH-1:0];
        else if (q < COORD_MIN)
            return COORD_MIN[COORD_WIDTH-1:0];
        else
            return q[COORD_WIDTH-1:0];
    endfunction

    logic en;

    logic [SIDE_W-1:0]        side_in;
    logic                     cordic_valid;
    logic signed [FACT_W-1:0] cos_val;
    logic signed [FACT_W-1:0] sin_val;
    logic [SIDE_W-1:0]        cordic_side;

    logic [1:0]                    ck;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic signed [COORD_WIDTH-1:0] u;
    logic signed [COORD_WIDTH-1:0] v;

    logic                          mult_valid_reg;
    logic signed [PROD_W-1:0]      cu_reg;
    logic signed [PROD_W-1:0]      sv_reg;
    logic signed [PROD_W-1:0]      su_reg;
    logic signed [PROD_W-1:0]      cv_reg;
    logic [1:0]                    mult_kind_reg;
    logic signed [COORD_WIDTH-1:0] mult_x_reg;
    logic signed [COORD_WIDTH-1:0] mult_y_reg;
    logic signed [COORD_WIDTH-1:0] mult_z_reg;

    logic                          sum_valid_reg;
    logic signed [COORD_WIDTH-1:0] r1_reg;
    logic signed [COORD_WIDTH-1:0] r2_reg;
    logic [1:0]                    sum_kind_reg;
    logic signed [COORD_WIDTH-1:0] sum_x_reg;
    logic signed [COORD_WIDTH-1:0] sum_y_reg;
    logic signed [COORD_WIDTH-1:0] sum_z_reg;

    logic                          out_valid_reg;
    logic signed [COORD_WIDTH-1:0] x_out_reg;
    logic signed [COORD_WIDTH-1:0] x_out_next;
    logic signed [COORD_WIDTH-1:0] y_out_reg;
    logic signed [COORD_WIDTH-1:0] y_out_next;
    logic signed [COORD_WIDTH-1:0] z_out_reg;
    logic signed [COORD_WIDTH-1:0] z_out_next;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;
    assign side_in  = {kind, x_in, y_in, z_in};

    ar3d_cordic #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .SIDE_WIDTH  (SIDE_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .angle     (angle),
        .side_in   (side_in),
        .out_valid (cordic_valid),
        .cos_val   (cos_val),
        .sin_val   (sin_val),
        .side_out  (cordic_side)
    );

    assign ck = cordic_side[SIDE_W-1 -: 2];
    assign cx = signed'(cordic_side[3*COORD_WIDTH-1 -: COORD_WIDTH]);
    assign cy = signed'(cordic_side[2*COORD_WIDTH-1 -: COORD_WIDTH]);
    assign cz = signed'(cordic_side[COORD_WIDTH-1:0]);

    // out1 = c*u - s*v, out2 = s*u + c*v
    always_comb
    begin
        case (ck)
            AXIS_X:
            begin
                u = cy;
                v = cz;
            end
            AXIS_Y:
            begin
                u = cz;
                v = cx;
            end
            default:
            begin
                u = cx;
                v = cy;
            end
        endcase
    end

    always_comb
    begin
        x_out_next = sum_x_reg;
        y_out_next = sum_y_reg;
        z_out_next = sum_z_reg;
        case (sum_kind_reg)
            AXIS_X:
            begin
                y_out_next = r1_reg;
                z_out_next = r2_reg;
            end
            AXIS_Y:
            begin
                z_out_next = r1_reg;
                x_out_next = r2_reg;
            end
            AXIS_Z:
            begin
                x_out_next = r1_reg;
                y_out_next = r2_reg;
            end
            AXIS_NONE:
            begin
                x_out_next = sum_x_reg;
            end
            default:
            begin
                x_out_next = sum_x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            mult_valid_reg <= cordic_valid;
            sum_valid_reg  <= mult_valid_reg;
            out_valid_reg  <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cu_reg        <= PROD_W'(cos_val) * PROD_W'(u);
            sv_reg        <= PROD_W'(sin_val) * PROD_W'(v);
            su_reg        <= PROD_W'(sin_val) * PROD_W'(u);
            cv_reg        <= PROD_W'(cos_val) * PROD_W'(v);
            mult_kind_reg <= ck;
            mult_x_reg    <= cx;
            mult_y_reg    <= cy;
            mult_z_reg    <= cz;

            r1_reg        <= round_sat(SUM_W'(cu_reg) - SUM_W'(sv_reg));
            r2_reg        <= round_sat(SUM_W'(su_reg) + SUM_W'(cv_reg));
            sum_kind_reg  <= mult_kind_reg;
            sum_x_reg     <= mult_x_reg;
            sum_y_reg     <= mult_y_reg;
            sum_z_reg     <= mult_z_reg;

            x_out_reg     <= x_out_next;
            y_out_reg     <= y_out_next;
            z_out_reg     <= z_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_out     = x_out_reg;
    assign y_out     = y_out_reg;
    assign z_out     = z_out_reg;

    // a held result freezes the stages behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(mult_valid_reg) && $stable(sum_valid_reg))
        else $error("pipeline moved while stalled");

    // a finished sum always reaches the output register when the pipe advances
    assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid_reg && !in_stall) |=> out_valid_reg)
        else $error("result lost between sum and output stage");

    // a stalled result stays valid and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            out_valid && $stable(x_out) && $stable(y_out) && $stable(z_out))
        else $error("stalled result changed");

endmodule

>>> bench/rotation_axis_pkg.sv
`timescale 1ns / 1ps

package rotation_axis_pkg;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

endpackage

>>> bench/axis_rotation_3d_checker.sv
`timescale 1ns / 1ps

module axis_rotation_3d_checker #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic signed [COORD_WIDTH-1:0] x_in,
    input  logic signed [COORD_WIDTH-1:0] y_in,
    input  logic signed [COORD_WIDTH-1:0] z_in,
    input  logic [ANGLE_WIDTH-1:0]        angle,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [COORD_WIDTH-1:0] x_out,
    input  logic signed [COORD_WIDTH-1:0] y_out,
    input  logic signed [COORD_WIDTH-1:0] z_out,
    output int                            mismatches,
    output int                            outstanding
);
    import rotation_axis_pkg::*;

    localparam int     STEPS    = 24;
    localparam longint GAIN_Q30 = 652032874;
    localparam longint HALF_LSB = 536870912;
    localparam int     MAX_SHOWN = 10;

    // arctangent of 2^-i in 2^-32 turn units
    localparam logic [0:STEPS-1][31:0] ARC_TURNS = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } point_t;

    point_t rotated_q[$];
    point_t expected;
    int     err_count = 0;

    function automatic void sin_cos_q30(input logic [ANGLE_WIDTH-1:0] ang,
                                        output longint c, output longint s);
        logic [31:0] phase;
        longint      cx;
        longint      cy;
        longint      cz;
        longint      tx;
        longint      ty;
        longint      arc;
        int          i;
        phase = 32'(ang) << (32 - ANGLE_WIDTH);
        cx = GAIN_Q30;
        cy = 0;
        cz = 0;
        cz[29:0] = phase[29:0];
        for (i = 0; i < STEPS; i++)
        begin
            tx = cx >>> i;
            ty = cy >>> i;
            arc = 0;
            arc[31:0] = ARC_TURNS[i];
            if (cz >= 0)
            begin
                cx = cx - ty;
                cy = cy + tx;
                cz = cz - arc;
            end
            else
            begin
                cx = cx + ty;
                cy = cy - tx;
                cz = cz + arc;
            end
        end
        case (phase[31:30])
            2'd1:
            begin
                c = -cy;
                s = cx;
            end
            2'd2:
            begin
                c = -cx;
                s = -cy;
            end
            2'd3:
            begin
                c = cy;
                s = -cx;
            end
            default:
            begin
                c = cx;
                s = cy;
            end
        endcase
    endfunction

    function automatic longint mix_q30(longint a, longint fa, longint b, longint fb);
        return (a * fa + b * fb + HALF_LSB) >>> 30;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(longint v);
        longint hi;
        longint lo;
        longint t;
        hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        t = v;
        if (t > hi)
            t = hi;
        if (t < lo)
            t = lo;
        return t[COORD_WIDTH-1:0];
    endfunction

    function automatic point_t rotate_point(logic [1:0] axis,
                                            logic signed [COORD_WIDTH-1:0] px,
                                            logic signed [COORD_WIDTH-1:0] py,
                                            logic signed [COORD_WIDTH-1:0] pz,
                                            logic [ANGLE_WIDTH-1:0] ang);
        longint c;
        longint s;
        longint x;
        longint y;
        longint z;
        longint rx;
        longint ry;
        longint rz;
        point_t r;
        x = px;
        y = py;
        z = pz;
        sin_cos_q30(ang, c, s);
        rx = x;
        ry = y;
        rz = z;
        case (axis_t'(axis))
            AXIS_X:
            begin
                ry = mix_q30(y, c, z, -s);
                rz = mix_q30(y, s, z, c);
            end
            AXIS_Y:
            begin
                rx = mix_q30(x, c, z, s);
                rz = mix_q30(x, -s, z, c);
            end
            AXIS_Z:
            begin
                rx = mix_q30(x, c, y, -s);
                ry = mix_q30(x, s, y, c);
            end
            default:
            begin
            end
        endcase
        r.x = clamp_coord(rx);
        r.y = clamp_coord(ry);
        r.z = clamp_coord(rz);
        return r;
    endfunction

    task automatic compare_coord(input string name,
                                 input logic signed [COORD_WIDTH-1:0] want,
                                 input logic signed [COORD_WIDTH-1:0] got);
        if (got !== want)
        begin
            err_count++;
            if (err_count <= MAX_SHOWN)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                rotated_q.push_back(rotate_point(kind, x_in, y_in, z_in, angle));
            if (out_valid && !out_stall)
            begin
                if (rotated_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("%0t: unexpected result (%0d, %0d, %0d)",
                                 $realtime, x_out, y_out, z_out);
                end
                else
                begin
                    expected = rotated_q.pop_front();
                    compare_coord("x_out", expected.x, x_out);
                    compare_coord("y_out", expected.y, y_out);
                    compare_coord("z_out", expected.z, z_out);
                end
            end
            mismatches  <= err_count;
            outstanding <= rotated_q.size();
        end
    end

endmodule

>>> bench/axis_rotation_3d_top_tb.sv
`timescale 1ns / 1ps

module axis_rotation_3d_top_tb;
    import rotation_axis_pkg::*;

    localparam int ITEMS       = 500;
    localparam int SEGMENT     = 50;
    localparam int HOLD_SEG    = 3;
    localparam int LATENCY     = 29;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 5000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
    logic signed [15:0] z_in;
    logic [15:0]        angle;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic signed [15:0] z_out;

    int   mismatches;
    int   outstanding;
    int   idle_cycles;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_request;
    logic hold_started;

    axis_rotation_3d_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .x_in      (x_in),
        .y_in      (y_in),
        .z_in      (z_in),
        .angle     (angle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .x_out     (x_out),
        .y_out     (y_out),
        .z_out     (z_out)
    );

    axis_rotation_3d_checker rotation_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .x_in        (x_in),
        .y_in        (y_in),
        .z_in        (z_in),
        .angle       (angle),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .x_out       (x_out),
        .y_out       (y_out),
        .z_out       (z_out),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 12);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic signed [15:0] pick_coord();
        logic signed [15:0] v;
        case ($urandom_range(9))
            0: v = 16'sh7fff;
            1: v = 16'sh8000;
            2, 3:
            begin
                v = 16'($urandom_range(511));
                v = v - 16'sd256;
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_angle();
        logic [15:0] a;
        a = 16'($urandom_range(3)) << 14;
        case ($urandom_range(7))
            0: return a;
            1: return a + 16'($urandom_range(4)) - 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_request(input logic [1:0] k, input logic signed [15:0] xv,
                                 input logic signed [15:0] yv, input logic signed [15:0] zv,
                                 input logic [15:0] av);
        int gap;
        gap = pick_gap(send_idle_pct);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind     = k;
        x_in     = xv;
        y_in     = yv;
        z_in     = zv;
        angle    = av;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // receiver
    initial
    begin
        int n;
        out_stall    = 1'b0;
        hold_started = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_started = 1'b1;
                out_stall    = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
            end
            else
            begin
                n = pick_gap(recv_idle_pct);
                out_stall = (n > 0);
                if (n > 1)
                    repeat (n - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int seg;
        int n;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = AXIS_X;
        x_in          = '0;
        y_in          = '0;
        z_in          = '0;
        angle         = '0;
        hold_request  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        offer_request(AXIS_X, 16'sh0100, 16'sh0200, 16'sh0300, 16'h0000);
        offer_request(AXIS_Y, 16'sh0100, 16'sh0200, 16'sh0300, 16'h4000);
        offer_request(AXIS_Z, 16'sh0100, 16'sh0200, 16'sh0300, 16'h8000);
        offer_request(AXIS_X, 16'sh0100, 16'sh0200, 16'sh0300, 16'hc000);
        offer_request(AXIS_Y, 16'sh0100, 16'sh0200, 16'sh0300, 16'hffff);
        offer_request(AXIS_Z, 16'sh0100, 16'sh0200, 16'sh0300, 16'h0001);
        offer_request(AXIS_X, 16'sh0400, 16'shfc00, 16'sh0800, 16'h3fff);
        offer_request(AXIS_Y, 16'shfc00, 16'sh0400, 16'sh0800, 16'h4001);
        offer_request(AXIS_Z, 16'sh0800, 16'shfc00, 16'sh0400, 16'hbfff);
        // saturation high and low
        offer_request(AXIS_Z, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'h2000);
        offer_request(AXIS_Z, 16'sh8000, 16'sh8000, 16'sh7fff, 16'h2000);
        offer_request(AXIS_X, 16'sh8000, 16'sh7fff, 16'sh8000, 16'he000);
        offer_request(AXIS_Y, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'h2000);
        // negating the most negative coordinate
        offer_request(AXIS_X, 16'sh8000, 16'sh8000, 16'sh8000, 16'h8000);
        offer_request(AXIS_Y, 16'sh8000, 16'sh7fff, 16'sh8000, 16'h8000);
        offer_request(AXIS_Z, 16'sh7fff, 16'sh8000, 16'sh8000, 16'h4000);
        // unused axis code passes through
        offer_request(AXIS_NONE, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'h1234);
        offer_request(AXIS_NONE, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000);
        offer_request(AXIS_NONE, 16'shffff, 16'sh8000, 16'sh0001, 16'hffff);
        offer_request(AXIS_X, 16'sh0000, 16'sh0000, 16'sh0000, 16'h5555);

        for (seg = 0; seg < ITEMS / SEGMENT; seg++)
        begin
            case ($urandom_range(2))
                0: send_idle_pct = 0;
                1: send_idle_pct = 15;
                default: send_idle_pct = 50;
            endcase
            case ($urandom_range(2))
                0: recv_idle_pct = 0;
                1: recv_idle_pct = 15;
                default: recv_idle_pct = 50;
            endcase
            if (seg == HOLD_SEG)
            begin
                send_idle_pct = 0;
                hold_request  = 1'b1;
                in_valid      = 1'b0;
                while (!hold_started)
                    @(negedge clk);
            end
            for (n = 0; n < SEGMENT; n++)
                offer_request(2'($urandom_range(3)), pick_coord(), pick_coord(),
                              pick_coord(), pick_angle());
        end
        in_valid = 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
